[hw/rtl/reacc_pkg.sv]
// shared types, widths and constants of the rotary encoder decoder
// no dependencies; imported by every module of the block

package reacc_pkg;

  localparam int PinW    = 8;
  localparam int TimeW   = 32;
  localparam int AmtW    = 13;
  localparam int PinIdxW = 3;
  localparam int DetW    = 4;
  localparam int WinW    = 8;
  localparam int GainW   = 4;
  localparam int CntW    = 5;
  localparam int PhaseW  = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 8;
  localparam int ProdW   = GainW + WinW;

  // largest rotation magnitude: 255 + 15 * 254
  localparam int AmtMax = 4065;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_PIN  = 3'd0,
    CFG_B_PIN  = 3'd1,
    CFG_DETENT = 3'd2,
    CFG_WINDOW = 3'd3,
    CFG_GAIN   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PinIdxW-1:0] a_pin;
    logic [PinIdxW-1:0] b_pin;
    logic [DetW-1:0]    detent;
    logic [WinW-1:0]    window;
    logic [GainW-1:0]   gain;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    a_pin:  3'd0,
    b_pin:  3'd1,
    detent: 4'd4,
    window: 8'd50,
    gain:   4'd4
  };

  // per-emission decision handed from the step decoder to the amount logic
  typedef struct packed {
    logic            neg;
    logic            accel;
    logic [WinW-1:0] delta;
  } dec_t;

endpackage

[hw/rtl/rotary_encoder_accel_decoder_top.sv]
// top level of the quadrature rotary encoder decoder with velocity acceleration
// depends on reacc_pkg, reacc_step and reacc_amount
//
//  channel   handshake             payload
//  in_       in_valid / in_ready   in_pin_levels[7:0], in_time_ms[31:0]
//  out_      out_valid / out_ready out_rotation_amount[12:0] signed
//  cfg_      cfg_wr_en             cfg_index[2:0], cfg_wdata[7:0]
//
// one item per cycle unless the output stalls; an accepted item passes the input register,
// then the result register, before it shows on out_; the step decoder and the amount logic
// both sit between them; phase, count and emit time update on each take for the next item
// items that cause no rotation are dropped before the result register
// reset is synchronous; it restores register defaults, clears valid flags and decoder state
// a stalled output blocks input only once the input and result registers both hold items

module rotary_encoder_accel_decoder_top import reacc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PinW-1:0]        in_pin_levels,
  input  logic [TimeW-1:0]       in_time_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [AmtW-1:0] out_rotation_amount,
  input  logic                   cfg_wr_en,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDatW-1:0]     cfg_wdata
);

  cfg_t cfg_r;

  // input register
  logic             s1_valid_r;
  logic [PinW-1:0]  s1_pins_r;
  logic [TimeW-1:0] s1_time_r;

  // result register, holds only items that emit
  logic                   out_valid_r;
  logic signed [AmtW-1:0] out_amount_r;

  logic                   out_free;
  logic                   s1_take;
  logic                   emit;
  dec_t                   dec;
  logic signed [AmtW-1:0] amount;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_A_PIN:  cfg_r.a_pin  <= cfg_wdata[PinIdxW-1:0];
        CFG_B_PIN:  cfg_r.b_pin  <= cfg_wdata[PinIdxW-1:0];
        CFG_DETENT: cfg_r.detent <= cfg_wdata[DetW-1:0];
        CFG_WINDOW: cfg_r.window <= cfg_wdata[WinW-1:0];
        CFG_GAIN:   cfg_r.gain   <= cfg_wdata[GainW-1:0];
        default:    ;
      endcase
    end
  end

  // stage flow control: the input register moves when the result register has room
  assign out_free = !out_valid_r || out_ready;
  assign s1_take  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pins_r <= in_pin_levels;
      s1_time_r <= in_time_ms;
    end
  end

  reacc_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pin_levels (s1_pins_r),
    .time_ms    (s1_time_r),
    .take       (s1_take),
    .emit       (emit),
    .dec        (dec)
  );

  reacc_amount u_amount (
    .cfg    (cfg_r),
    .dec    (dec),
    .amount (amount)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && emit) begin
      out_amount_r <= amount;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rotation_amount = out_amount_r;

endmodule

[hw/rtl/reacc_step.sv]
// quadrature step decoder: phase tracking, detent counting, emission decision
// depends on reacc_pkg

module reacc_step import reacc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic [PinW-1:0]  pin_levels,
  input  logic [TimeW-1:0] time_ms,
  input  logic             take,
  output logic             emit,
  output dec_t             dec
);

  logic [PhaseW-1:0]      last_phase_r;
  logic signed [CntW-1:0] step_cnt_r;
  logic [TimeW-1:0]       last_emit_time_r;
  logic                   emitted_r;

  logic                   pin_a;
  logic                   pin_b;
  logic [PhaseW-1:0]      phase;
  logic [PhaseW-1:0]      diff;
  logic                   changed;
  logic signed [CntW-1:0] cnt_step;
  logic signed [CntW:0]   cnt_ext;
  logic [CntW:0]          mag;
  logic [DetW-1:0]        detent_eff;
  logic [TimeW-1:0]       interval;
  logic signed [CntW-1:0] step_cnt_nxt;

  assign pin_a   = pin_levels[cfg.a_pin];
  assign pin_b   = pin_levels[cfg.b_pin];
  assign phase   = {pin_b, pin_a ^ pin_b};
  assign diff    = phase - last_phase_r;
  assign changed = (phase != last_phase_r);

  always_comb begin
    case (diff)
      2'd1:    cnt_step = step_cnt_r + 5'sd1;
      2'd3:    cnt_step = step_cnt_r - 5'sd1;
      default: cnt_step = step_cnt_r;
    endcase
  end

  assign cnt_ext    = {cnt_step[CntW-1], cnt_step};
  assign mag        = cnt_ext[CntW] ? (CntW+1)'(-cnt_ext) : (CntW+1)'(cnt_ext);
  assign detent_eff = (cfg.detent == '0) ? DetW'(1) : cfg.detent;
  assign emit       = changed && (mag >= (CntW+1)'(detent_eff));

  // wrapping interval since the last emission
  assign interval  = time_ms - last_emit_time_r;
  assign dec.accel = emitted_r && (interval != '0) &&
                     (interval <= TimeW'(cfg.window));
  assign dec.delta = cfg.window - interval[WinW-1:0];
  assign dec.neg   = cnt_step[CntW-1];

  assign step_cnt_nxt = emit ? '0 : cnt_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r     <= '0;
      step_cnt_r       <= '0;
      last_emit_time_r <= '0;
      emitted_r        <= 1'b0;
    end else if (take) begin
      last_phase_r <= phase;
      step_cnt_r   <= step_cnt_nxt;
      if (emit) begin
        last_emit_time_r <= time_ms;
        emitted_r        <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/reacc_amount.sv]
// rotation amount: window, plus scaled acceleration when accelerated, signed by direction
// depends on reacc_pkg

module reacc_amount import reacc_pkg::*; (
  input  cfg_t                   cfg,
  input  dec_t                   dec,
  output logic signed [AmtW-1:0] amount
);

  logic [ProdW-1:0] prod;
  logic [AmtW-1:0]  mag;

  assign prod = ProdW'(cfg.gain) * ProdW'(dec.delta);
  assign mag  = dec.accel ? AmtW'(cfg.window) + AmtW'(prod) : AmtW'(cfg.window);

  always_comb begin
    if (dec.neg) begin
      amount = $signed(-mag);
    end else begin
      amount = $signed(mag);
    end
  end

endmodule

[hw/rtl/reacc_checker.sv]
// port-level checker for the rotary encoder decoder, bound to the top level
// depends on reacc_pkg and rotary_encoder_accel_decoder_top

module reacc_checker import reacc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [AmtW-1:0] out_rotation_amount
);

  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rotation_amount))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // an empty result register never blocks input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // rotation amount stays within its range
  a_amount_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rotation_amount <= AmtW'(AmtMax)) &&
                  (out_rotation_amount >= -AmtW'(AmtMax)))
    else $error("rotation amount out of range");

endmodule

bind rotary_encoder_accel_decoder_top reacc_checker u_reacc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_rotation_amount (out_rotation_amount)
);

[test/testbench.sv]
// self-checking testbench of rotary_encoder_accel_decoder_top
// depends on reacc_pkg and the decoder RTL; predicts every rotation in its own model

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import reacc_pkg::*;

  localparam int RandomItems = 1700;
  localparam int Segments    = 16;
  localparam int DrainCycles = 4;
  localparam int DrainLimit  = 20000;
  localparam int CycleLimit  = 500000;
  localparam int MaxPrinted  = 50;

  // dut ports
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PinW-1:0]        in_pin_levels = '0;
  logic [TimeW-1:0]       in_time_ms = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [AmtW-1:0] out_rotation_amount;
  logic                   cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]     cfg_index = '0;
  logic [CfgDatW-1:0]     cfg_wdata = '0;

  // decoder model: register copies and state
  logic [PinIdxW-1:0]     a_pin_q, b_pin_q;
  logic [DetW-1:0]        detent_q;
  logic [WinW-1:0]        window_q;
  logic [GainW-1:0]       gain_q;
  logic [PhaseW-1:0]      phase_q;
  logic signed [CntW-1:0] step_count_q;
  logic [TimeW-1:0]       last_emit_ms;
  logic                   emitted_any;

  // rotations still owed by the dut, oldest first
  logic signed [AmtW-1:0] expected_rotations[$];

  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [TimeW-1:0] now_ms = '0;

  rotary_encoder_accel_decoder_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pin_levels       (in_pin_levels),
    .in_time_ms          (in_time_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rotation_amount (out_rotation_amount),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #1 clk = ~clk;

  // run limit, reckoned far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d rotations pending", cycle_count,
               expected_rotations.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random back-pressure on the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MaxPrinted)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    logic signed [AmtW-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rotations.size() == 0) begin
        report_mismatch($sformatf("unexpected rotation %0d", out_rotation_amount));
      end else begin
        want = expected_rotations.pop_front();
        if (out_rotation_amount !== want)
          report_mismatch($sformatf("rotation_amount %0d, expected %0d",
                                    out_rotation_amount, want));
      end
    end
  end

  function automatic void reset_model();
    a_pin_q      = 3'd0;
    b_pin_q      = 3'd1;
    detent_q     = 4'd4;
    window_q     = 8'd50;
    gain_q       = 4'd4;
    phase_q      = '0;
    step_count_q = '0;
    last_emit_ms = '0;
    emitted_any  = 1'b0;
  endfunction

  // decode one accepted item and queue the rotation it causes, if any
  function automatic void predict_rotation(input logic [PinW-1:0] pins,
                                           input logic [TimeW-1:0] stamp);
    logic              a_bit, b_bit;
    logic [PhaseW-1:0] ph, diff;
    logic [TimeW-1:0]  interval;
    int                cnt, mag, det, amt;
    a_bit = pins[a_pin_q];
    b_bit = pins[b_pin_q];
    ph = {b_bit, a_bit ^ b_bit};
    // unchanged phase leaves everything as it was
    if (ph == phase_q)
      return;
    diff = ph - phase_q;
    phase_q = ph;
    if (diff == 2'd1)
      step_count_q = step_count_q + 5'sd1;
    else if (diff == 2'd3)
      step_count_q = step_count_q - 5'sd1;
    // a jump of two still goes through the detent test
    cnt = step_count_q;
    det = (detent_q == 0) ? 1 : int'(detent_q);
    mag = (cnt < 0) ? -cnt : cnt;
    if (mag < det)
      return;
    interval = stamp - last_emit_ms;
    amt = int'(window_q);
    if (emitted_any && interval != 0 && interval <= window_q)
      amt = int'(window_q) + int'(gain_q) * (int'(window_q) - int'(interval));
    if (cnt < 0)
      amt = -amt;
    last_emit_ms = stamp;
    emitted_any  = 1'b1;
    step_count_q = '0;
    expected_rotations.push_back(amt[AmtW-1:0]);
  endfunction

  // pin byte that shows the given phase under the current pin mapping
  function automatic logic [PinW-1:0] pins_for_phase(input logic [PhaseW-1:0] p);
    logic [PinW-1:0] pins;
    pins = PinW'($urandom);
    pins[b_pin_q] = p[1];
    pins[a_pin_q] = p[0] ^ p[1];
    return pins;
  endfunction

  // send one item; valid stays up when the next item follows without a gap
  task automatic send_item(input logic [PinW-1:0] pins, input logic [TimeW-1:0] stamp);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_pin_levels <= pins;
    in_time_ms    <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_rotation(pins, stamp);
  endtask

  // move the phase by delta (mod 4) after dt milliseconds
  task automatic step_by(input int delta, input logic [TimeW-1:0] dt);
    logic [PhaseW-1:0] target;
    target = PhaseW'(int'(phase_q) + delta);
    now_ms = now_ms + dt;
    send_item(pins_for_phase(target), now_ms);
  endtask

  // stop sending, collect every owed rotation, let dropped items leave the pipe
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_rotations.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    while (expected_rotations.size() != 0)
      report_mismatch($sformatf("missing rotation %0d", expected_rotations.pop_front()));
  endtask

  // one register write; bits above the register width carry junk
  task automatic write_reg(input cfg_idx_t idx, input int value);
    logic [CfgDatW-1:0] junk, data;
    junk = CfgDatW'($urandom);
    data = CfgDatW'(value);
    case (idx)
      CFG_A_PIN: begin
        data[CfgDatW-1:PinIdxW] = junk[CfgDatW-1:PinIdxW];
        a_pin_q = data[PinIdxW-1:0];
      end
      CFG_B_PIN: begin
        data[CfgDatW-1:PinIdxW] = junk[CfgDatW-1:PinIdxW];
        b_pin_q = data[PinIdxW-1:0];
      end
      CFG_DETENT: begin
        data[CfgDatW-1:DetW] = junk[CfgDatW-1:DetW];
        detent_q = data[DetW-1:0];
      end
      CFG_WINDOW: begin
        window_q = data[WinW-1:0];
      end
      CFG_GAIN: begin
        data[CfgDatW-1:GainW] = junk[CfgDatW-1:GainW];
        gain_q = data[GainW-1:0];
      end
      default: ;
    endcase
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input int a_pin, input int b_pin, input int detent,
                            input int window, input int gain);
    wait_drained();
    write_reg(CFG_A_PIN, a_pin);
    write_reg(CFG_B_PIN, b_pin);
    write_reg(CFG_DETENT, detent);
    write_reg(CFG_WINDOW, window);
    write_reg(CFG_GAIN, gain);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // reset defaults: first rotation unaccelerated, then an accelerated turn back
  task automatic test_default_config();
    now_ms = 32'd10;
    repeat (4) step_by(1, 1);
    step_by(0, 1);
    repeat (4) step_by(-1, 5);
  endtask

  // detent zero, largest window and gain, zero interval, jump of two, detent lowered
  task automatic test_detent_and_jumps();
    set_config(0, 1, 0, 255, 15);
    step_by(1, 1);
    step_by(-1, 0);
    step_by(2, 3);
    set_config(0, 1, 8, 255, 15);
    repeat (5) step_by(1, 1);
    // count now above the new detent: the next change emits, a jump included
    set_config(0, 1, 2, 255, 15);
    step_by(2, 300);
  endtask

  // window zero, a shared pin, high pins and a wrapping timestamp
  task automatic test_window_and_pins();
    set_config(7, 3, 1, 0, 0);
    step_by(1, 1);
    set_config(5, 5, 1, 50, 4);
    step_by(1, 1);
    step_by(2, 1);
    set_config(6, 2, 1, 100, 3);
    now_ms = 32'hFFFF_FFF0;
    step_by(1, 0);
    step_by(1, 32'h20);
  endtask

  // timestamp advance, mostly on the scale of the acceleration window
  function automatic logic [TimeW-1:0] next_dt();
    int det, r;
    det = (detent_q == 0) ? 1 : int'(detent_q);
    r = $urandom_range(99);
    if (r < 10)
      return '0;
    else if (r < 75)
      return $urandom_range(2 * int'(window_q) / det + 1, 0);
    else if (r < 92)
      return $urandom_range(1000, 0);
    else
      return $urandom;
  endfunction

  // random turning under random settings and every idling mode
  task automatic test_random_traffic();
    int send_pcts[4] = '{0, 83, 0, 17};
    int recv_pcts[4] = '{0, 0, 83, 17};
    int a_pin, b_pin, det, win, r, delta, dir, done;
    dir = 1;
    for (int seg = 0; seg < Segments; seg++) begin
      a_pin = $urandom_range(7);
      b_pin = ($urandom_range(9) == 0) ? a_pin : $urandom_range(7);
      r = $urandom_range(9);
      det = (r == 0) ? 0 : (r == 1) ? $urandom_range(15, 9) : $urandom_range(8, 1);
      r = $urandom_range(9);
      win = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 255 : $urandom_range(255, 1);
      set_config(a_pin, b_pin, det, win, $urandom_range(15));
      send_idle_pct  = send_pcts[seg % 4];
      recv_stall_pct = recv_pcts[seg % 4];
      done = 0;
      while (done < RandomItems / Segments) begin
        if ($urandom_range(99) < 8)
          dir = -dir;
        r = $urandom_range(99);
        // mostly clean turning in runs, with jumps, repeats and noise mixed in
        if (r < 78)
          delta = dir;
        else if (r < 86)
          delta = 2;
        else if (r < 92)
          delta = 0;
        else
          delta = $urandom_range(3);
        step_by(delta, next_dt());
        done++;
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic finish_run();
    wait_drained();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_detent_and_jumps();
    test_window_and_pins();
    test_random_traffic();
    finish_run();
  end

endmodule
